// ===== design/bccwf_pkg.sv =====
// Shared types and constants for the bounded clip/wrap/fold counter.
`timescale 1ns / 1ps

package bccwf_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int DEN_W     = 33;

	localparam logic [OP_W-1:0] OP_COUNT     = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD      = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_EMIT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_CLIP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRAP = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_DIV,
		ST_POST1,
		ST_POST2,
		ST_SAT,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic check;
		logic post1;
		logic post2;
		logic sat;
		logic add;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            need_div;
		logic            div_done;
		logic            out_free;
	} status_t;

endpackage

// ===== design/bccwf_rem.sv =====
// Radix-2 restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module bccwf_rem
	import bccwf_pkg::*;
#(
	parameter int NUM_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[DEN_W-1:0];
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
		end
	end

	assign done = !busy_q;
	assign rem  = rem_q;

endmodule

// ===== design/bccwf_dp.sv =====
// Datapath: configuration registers, count state, bounding arithmetic, output register.
`timescale 1ns / 1ps

module bccwf_dp
	import bccwf_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic [OP_W-1:0]      in_op,
	input  logic [DATA_W-1:0]    in_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    out_data,
	output logic [1:0]           out_user
);

	localparam int MW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
	localparam int EW = MW + 2;
	localparam logic [DATA_W-1:0] STEP_RST  = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] LOWER_RST = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] UPPER_RST = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [EW-1:0] VMAX_E =
		{{(EW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;

	logic [DATA_W-1:0]      step_q;
	logic [MODE_W-1:0]      mode_q;
	logic [DATA_W-1:0]      lower_q;
	logic [DATA_W-1:0]      upper_q;
	logic                   rev_q;
	logic [VALUE_WIDTH-1:0] count_q;
	logic [OP_W-1:0]        op_q;
	logic [DATA_W-1:0]      opnd_q;
	logic [DATA_W-1:0]      lo_q;
	logic [DATA_W-1:0]      hi_q;
	logic signed [EW-1:0]   v_q;
	logic                   fl_q;
	logic                   ce_q;
	logic                   below_q;
	logic                   fold_q;
	logic                   out_valid_q;
	logic [DATA_W-1:0]      out_data_q;
	logic [1:0]             out_user_q;

	logic signed [EW-1:0]   cnt_e;
	logic signed [EW-1:0]   src;
	logic signed [EW-1:0]   lo_e;
	logic signed [EW-1:0]   hi_e;
	logic signed [EW-1:0]   span;
	logic signed [EW-1:0]   gap;
	logic signed [EW-1:0]   d_e;
	logic signed [EW-1:0]   a_wrap;
	logic signed [EW-1:0]   a_fold;
	logic signed [EW-1:0]   sum;
	logic signed [EW-1:0]   step_e;
	logic signed [DATA_W:0] step_x;
	logic                   below;
	logic                   above;
	logic                   flat;
	logic                   clip_path;
	logic                   fold_mode;
	logic                   need_div;
	logic [DEN_W-1:0]       den;
	logic [DEN_W-1:0]       rem;
	logic                   rem_done;

	assign cnt_e = {{(EW-VALUE_WIDTH){count_q[VALUE_WIDTH-1]}}, count_q};
	assign lo_e  = {{(EW-DATA_W){lo_q[DATA_W-1]}}, lo_q};
	assign hi_e  = {{(EW-DATA_W){hi_q[DATA_W-1]}}, hi_q};
	assign src   = (op_q == OP_COUNT) ? cnt_e : {{(EW-DATA_W){opnd_q[DATA_W-1]}}, opnd_q};

	assign below     = src < lo_e;
	assign above     = src > hi_e;
	assign flat      = lo_q == hi_q;
	assign fold_mode = (mode_q != MODE_CLIP) && (mode_q != MODE_WRAP);
	assign clip_path = (op_q == OP_LOAD_EMIT) || ((op_q == OP_COUNT) && (mode_q == MODE_CLIP));
	assign need_div  = (op_q == OP_COUNT) && (mode_q != MODE_CLIP) && (below || above) && !flat;

	assign span = hi_e - lo_e;
	assign gap  = below ? (lo_e - src) : (src - hi_e);
	assign den  = fold_mode ? DEN_W'(span <<< 1) : DEN_W'(span);

	bccwf_rem #(
		.NUM_W(MW)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.check && need_div),
		.num   (gap[MW-1:0]),
		.den   (den),
		.done  (rem_done),
		.rem   (rem)
	);

	assign d_e    = {{(EW-DEN_W){1'b0}}, rem};
	assign a_wrap = below_q ? (hi_e - d_e) : (lo_e + d_e);
	assign a_fold = below_q ? (lo_e + d_e) : (hi_e - d_e);

	assign step_x = {step_q[DATA_W-1], step_q};
	assign step_e = rev_q ? EW'(-step_x) : {{(EW-DATA_W-1){step_x[DATA_W]}}, step_x};
	assign sum    = cnt_e + step_e;

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RST;
			mode_q  <= MODE_CLIP;
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
			rev_q   <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP: begin
						step_q <= cfg_data;
						rev_q  <= 1'b0;
					end
					CFG_MODE:  mode_q  <= cfg_data[MODE_W-1:0];
					CFG_LOWER: lower_q <= cfg_data;
					CFG_UPPER: upper_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.check && need_div && fold_mode) begin
				rev_q <= !rev_q;
			end
			if (cmd.sat) begin
				if (v_q > VMAX_E) begin
					count_q <= VMAX_E[VALUE_WIDTH-1:0];
				end else if (v_q < VMIN_E) begin
					count_q <= VMIN_E[VALUE_WIDTH-1:0];
				end else begin
					count_q <= v_q[VALUE_WIDTH-1:0];
				end
			end else if (cmd.add) begin
				if (sum > VMAX_E) begin
					count_q <= VMAX_E[VALUE_WIDTH-1:0];
				end else if (sum < VMIN_E) begin
					count_q <= VMIN_E[VALUE_WIDTH-1:0];
				end else begin
					count_q <= sum[VALUE_WIDTH-1:0];
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_op;
			opnd_q <= in_value;
		end
		if (cmd.load) begin
			if ($signed(lower_q) > $signed(upper_q)) begin
				lo_q <= upper_q;
				hi_q <= lower_q;
			end else begin
				lo_q <= lower_q;
				hi_q <= upper_q;
			end
		end
		if (cmd.check) begin
			below_q <= below;
			fold_q  <= fold_mode;
			if (clip_path) begin
				fl_q <= below && !above;
				ce_q <= above;
				v_q  <= above ? hi_e : (below ? lo_e : src);
			end else begin
				fl_q <= need_div && below;
				ce_q <= need_div && above;
				v_q  <= src;
			end
		end
		if (cmd.post1) begin
			v_q <= fold_q ? a_fold : a_wrap;
		end
		if (cmd.post2 && fold_q) begin
			if (below_q && (v_q > hi_e)) begin
				v_q <= (hi_e <<< 1) - v_q;
			end else if (!below_q && (v_q <= lo_e)) begin
				v_q <= (lo_e <<< 1) - v_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= v_q[DATA_W-1:0];
			out_user_q <= {ce_q, fl_q};
		end
	end

	assign status.op       = op_q;
	assign status.need_div = need_div;
	assign status.div_done = rem_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// ===== design/bccwf_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
`timescale 1ns / 1ps

module bccwf_ctrl
	import bccwf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_CHECK;
			ST_CHECK: begin
				if (status.op != OP_COUNT && status.op != OP_LOAD
						&& status.op != OP_LOAD_EMIT) begin
					state_d = ST_IDLE;
				end else if (status.need_div) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_SAT;
				end
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_POST1;
			end
			ST_POST1: state_d = ST_POST2;
			ST_POST2: state_d = ST_SAT;
			ST_SAT: begin
				case (status.op)
					OP_COUNT:     state_d = ST_ADD;
					OP_LOAD_EMIT: state_d = ST_EMIT;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_ADD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = state_q == ST_IDLE;
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.load   = state_q == ST_LOAD;
		cmd.check  = state_q == ST_CHECK;
		cmd.post1  = state_q == ST_POST1;
		cmd.post2  = state_q == ST_POST2;
		cmd.sat    = state_q == ST_SAT;
		cmd.add    = state_q == ST_ADD;
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
	end

endmodule

// ===== design/bounded_counter_clip_wrap_fold.sv =====
// Bounded up/down counter with clip, wrap and fold modes.
// One item at a time: load the bounds, check, saturate, add the step for a count, then emit
// unless the op is a plain load; wrap or fold out of bounds first runs the radix-2 remainder loop.
// The next input is taken once the item is done; a result still held at the output stalls
// the next emit.
// Reset (arst_n low, asynchronous): count 0, step 1.0, clip mode, full bounds, no reversal.
`timescale 1ns / 1ps

module bounded_counter_clip_wrap_fold
	import bccwf_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [DATA_W-1:0]    s_axis_tdata,  // [31:0] operand_value
	input  logic [OP_W-1:0]      s_axis_tuser,  // [1:0] opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DATA_W-1:0]    m_axis_tdata,  // [31:0] count_out
	output logic [1:0]           m_axis_tuser,  // [0] hit_floor, [1] hit_ceiling
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	bccwf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	bccwf_dp #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_op    (s_axis_tuser),
		.in_value (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("floor and ceiling flags both set");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.emit))
		else $error("result appeared without an emit command");

endmodule
